@@ hw/rtl/spc_pkg.sv @@
// Package for the stepper position controller: phase codes, widths and the result word.
package spc_pkg;

  localparam int unsigned PosW    = 16;
  localparam int unsigned CountOutW = 6;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [1:0] {
    PH_HOMING = 2'd0,
    PH_IDLE   = 2'd1,
    PH_MOVING = 2'd2
  } phase_e;

  typedef enum logic {
    MODE_TICK    = 1'b0,
    MODE_ENQUEUE = 1'b1
  } mode_e;

  // Result word, lowest bit last in the struct so it packs straight into tdata.
  typedef struct packed {
    logic [4:0]           pad;
    logic                 dropped;
    logic [CountOutW-1:0] queued_count;
    logic [PosW-1:0]      position_goal;
    logic [PosW-1:0]      position_now;
    logic [1:0]           phase;
    logic                 step_right;
    logic                 step_left;
  } result_t;

endpackage

@@ hw/rtl/stepper_position_controller_with_homing_core.sv @@
// Stepper position controller with homing and a target queue held in RAM.
// Throughput: one word per cycle on s_axis while the skid stage is empty; every word gives exactly one result word.
// The result word is registered in the output stage, or in the skid stage while m_axis stalls, before m_axis_tvalid_o.
// The queue head is read ahead from the RAM at the next read pointer; a
// write to that same entry is forwarded, so a pop right after a push sees the new target.
// Reset (rst_ni low, async) puts the block in homing with positions, pointers and count at zero.
module stepper_position_controller_with_homing_core #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input side
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [spc_pkg::InDataW-1:0]  s_axis_tdata_i,  // target_position[15:0], home_detected[16]
  input  logic                         s_axis_tuser_i,  // mode
  // result side
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // step_left[0], step_right[1], phase[3:2], position_now[19:4],
  // position_goal[35:20], queued_count[41:36], dropped[42]
  output logic [spc_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AddrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PosW   = spc_pkg::PosW;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic            in_acc;
  spc_pkg::mode_e  in_mode;
  logic [PosW-1:0] in_target;
  logic            in_home;

  assign in_acc    = s_axis_tvalid_i & s_axis_tready_o;
  assign in_mode   = spc_pkg::mode_e'(s_axis_tuser_i);
  assign in_target = s_axis_tdata_i[PosW-1:0];
  assign in_home   = s_axis_tdata_i[PosW];

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  spc_pkg::phase_e   phase_q, phase_d;
  logic [PosW-1:0]   cur_q, cur_d;
  logic [PosW-1:0]   goal_q, goal_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              fwd_q, fwd_d;       // head comes from the forwarding register
  logic [PosW-1:0]   fwd_data_q;

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  logic            drop;
  logic            is_tick;
  logic [PosW-1:0] ram_rdata;
  logic [PosW-1:0] head;
  logic [PosW-1:0] eff_goal;
  logic            eff_moving;
  logic            go_left;
  logic            go_right;
  logic            step_left;
  logic            step_right;

  assign q_full  = (count_q == CountW'(QUEUE_DEPTH));
  assign q_empty = (count_q == '0);
  assign is_tick = in_acc & (in_mode == spc_pkg::MODE_TICK);
  assign push    = in_acc & (in_mode == spc_pkg::MODE_ENQUEUE) & ~q_full;
  assign drop    = in_acc & (in_mode == spc_pkg::MODE_ENQUEUE) & q_full;

  // Homing and moving never pop; idle (and the unused code) may pop.
  assign pop = is_tick & ~q_empty
             & (phase_q != spc_pkg::PH_HOMING) & (phase_q != spc_pkg::PH_MOVING);

  assign head       = fwd_q ? fwd_data_q : ram_rdata;
  assign eff_goal   = pop ? head : goal_q;
  assign eff_moving = pop | (phase_q == spc_pkg::PH_MOVING);
  assign go_left    = cur_q > eff_goal;
  assign go_right   = cur_q < eff_goal;

  function automatic logic [AddrW-1:0] next_ptr(input logic [AddrW-1:0] p);
    next_ptr = (p == AddrW'(QUEUE_DEPTH - 1)) ? '0 : p + AddrW'(1);
  endfunction

  // Queue pointers and count.
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = next_ptr(wr_ptr_q);
      count_d  = count_q + CountW'(1);
    end
    if (pop) begin
      rd_ptr_d = next_ptr(rd_ptr_q);
      count_d  = count_q - CountW'(1);
    end
  end

  // Next phase and positions.
  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    goal_d  = eff_goal;
    if (is_tick) begin
      if (eff_moving) begin
        if (go_left) begin
          cur_d   = cur_q - PosW'(1);
          phase_d = spc_pkg::PH_MOVING;
        end else if (go_right) begin
          cur_d   = cur_q + PosW'(1);
          phase_d = spc_pkg::PH_MOVING;
        end else begin
          phase_d = spc_pkg::PH_IDLE;
        end
      end else begin
        case (phase_q)
          spc_pkg::PH_HOMING: begin
            if (in_home) begin
              phase_d = spc_pkg::PH_IDLE;
              cur_d   = '0;
              goal_d  = '0;
            end
          end
          default: begin
            phase_d = (cur_q != goal_q) ? spc_pkg::PH_MOVING : spc_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Step outputs.
  always_comb begin
    step_left  = 1'b0;
    step_right = 1'b0;
    if (is_tick) begin
      if (eff_moving) begin
        step_left  = go_left;
        step_right = go_right;
      end else begin
        case (phase_q)
          spc_pkg::PH_HOMING: step_right = ~in_home;
          default:            step_right = 1'b0;
        endcase
      end
    end
  end

  // A push into the entry being read this cycle would be missed by the RAM read.
  assign fwd_d = push ? (wr_ptr_q == rd_ptr_d) : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= spc_pkg::PH_HOMING;
      cur_q    <= '0;
      goal_q   <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
      fwd_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q  <= phase_d;
        cur_q    <= cur_d;
        goal_q   <= goal_d;
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        count_q  <= count_d;
      end
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fwd_data_q <= in_target;
    end
  end

  // Target queue storage; read every cycle at the next head pointer.
  spc_ram #(
    .Width (PosW),
    .Depth (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_target),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result word and output skid stage
  // ---------------------------------------------------------------------------
  spc_pkg::result_t res;
  logic [31:0]      count_ext;

  assign count_ext = 32'(count_d);

  always_comb begin
    res               = '0;
    res.step_left     = step_left;
    res.step_right    = step_right;
    res.phase         = phase_d;
    res.position_now  = cur_d;
    res.position_goal = goal_d;
    res.queued_count  = count_ext[spc_pkg::CountOutW-1:0];
    res.dropped       = drop;
  end

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  spc_pkg::result_t out_data_q;
  spc_pkg::result_t skid_data_q;
  logic             load_out;
  logic             load_skid;
  logic             skid_to_out;

  assign s_axis_tready_o = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    skid_to_out  = 1'b0;
    if (skid_valid_q) begin
      if (m_axis_tready_i) begin
        skid_to_out  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || m_axis_tready_i) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= res;
    end else if (skid_to_out) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ hw/rtl/spc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module spc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
